### src/ipbox_pkg.sv
// shared types, constants and helpers for the in-place box smoothing core
`default_nettype none

package ipbox_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int CFG_W_BITS = 10;
    localparam int CFG_H_BITS = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int SUM_W      = 12;
    localparam int PROD_W     = 25;
    localparam int FRAME_MIN  = 3;
    localparam int RESET_DIM  = 384;
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_SHIFT = 16;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                tick;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } ipbox_evt_t;

    typedef struct packed {
        logic                  clear;
        logic [CFG_W_BITS-1:0] width;
        logic [CFG_H_BITS-1:0] height;
    } ipbox_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed;
        logic                frame_end;
    } ipbox_res_t;

    // truncating divide by nine through a scaled reciprocal, exact for sums below 2304
    function automatic logic [SAMPLE_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: SAMPLE_W];
    endfunction

endpackage

`default_nettype wire

### src/ipbox_if.sv
// stream channel interfaces for samples and smoothed results
`default_nettype none

interface ipbox_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink (input valid, input req_type, input sample, output ready);
endinterface

interface ipbox_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] smoothed;
    logic       frame_end;

    modport source (output valid, output smoothed, output frame_end, input ready);
    modport sink (input valid, input smoothed, input frame_end, output ready);
endinterface

`default_nettype wire

### src/ipbox_cfg.sv
// apb register block holding frame width and height
`default_nettype none

module ipbox_cfg #(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ipbox_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ipbox_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ipbox_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready,
    output ipbox_pkg::ipbox_cfg_t               cfg
);
    import ipbox_pkg::*;

    localparam int WIDTH_CAP = (MAX_WIDTH > 1023) ? 1023 : MAX_WIDTH;

    logic [CFG_W_BITS-1:0] frame_width_reg;
    logic [CFG_H_BITS-1:0] frame_height_reg;
    logic                  wr_en;
    logic                  reg_sel;
    logic [CFG_W_BITS-1:0] width_used;
    logic [CFG_H_BITS-1:0] height_used;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_W_BITS'(RESET_DIM);
            frame_height_reg <= CFG_H_BITS'(RESET_DIM);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W_BITS-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (frame_width_reg < CFG_W_BITS'(FRAME_MIN))
            width_used = CFG_W_BITS'(FRAME_MIN);
        else if (frame_width_reg > CFG_W_BITS'(WIDTH_CAP))
            width_used = CFG_W_BITS'(WIDTH_CAP);
        else
            width_used = frame_width_reg;
        if (frame_height_reg < CFG_H_BITS'(FRAME_MIN))
            height_used = CFG_H_BITS'(FRAME_MIN);
        else
            height_used = frame_height_reg;
    end

    // a write restarts every pass at the first position of a frame
    assign cfg.clear  = wr_en;
    assign cfg.width  = width_used;
    assign cfg.height = height_used;

endmodule

`default_nettype wire

### src/ipbox_stage.sv
// one smoothing pass: pending sample queue, output history and 3x3 sum
`default_nettype none

module ipbox_stage #(
    parameter int MAX_WIDTH = 512
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  ipbox_pkg::ipbox_cfg_t      cfg,
    input  ipbox_pkg::ipbox_evt_t      ev_in,
    output ipbox_pkg::ipbox_evt_t      ev_out
);
    import ipbox_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_WIDTH + 3);
    localparam int FD = MAX_WIDTH + 2;
    localparam int FA = $clog2(FD);
    localparam int DD = MAX_WIDTH;
    localparam int DA = $clog2(DD);

    // pending raw samples and history of released samples
    logic [SAMPLE_W-1:0] raw_mem [FD];
    logic [SAMPLE_W-1:0] hist_mem [DD];

    logic [FW-1:0]         fill_reg, fill_next;
    logic [CW-1:0]         col_reg, col_next;
    logic [CFG_H_BITS-1:0] row_reg, row_next;
    logic [FA-1:0]         rptr_reg, rptr_next, wptr_reg, wptr_next, rd1_addr;
    logic [DA-1:0]         dptr_reg, dptr_next;
    logic                  fwd0_reg, fwd1_reg;
    logic [SAMPLE_W-1:0]   rd0_reg, rd1_reg, wr_data_reg;
    logic [SAMPLE_W-1:0]   t1_reg, t2_reg;
    logic [SAMPLE_W-1:0]   p1_reg, up_reg, up_left_reg, up_right_reg;
    logic                  evo_valid_reg, evo_tick_reg, evo_last_reg;
    logic [SAMPLE_W-1:0]   evo_value_reg;

    logic [WW-1:0]         w_use;
    logic                  at_last_col, at_last_row, border, is_full;
    logic                  store, release_ok, store_en, release_en;
    logic [SAMPLE_W-1:0]   h0, h1, rel_val;
    logic [SUM_W-1:0]      sum;

    assign w_use       = WW'(cfg.width);
    assign at_last_col = WW'(col_reg) == (w_use - WW'(1));
    assign at_last_row = row_reg == (cfg.height - CFG_H_BITS'(1));
    assign border      = (row_reg == '0) || at_last_row || (col_reg == '0) || at_last_col;
    assign is_full     = fill_reg == (FW'(w_use) + FW'(1));

    assign store      = ev_in.valid && !ev_in.tick;
    assign release_ok = ev_in.valid && (ev_in.tick ? ((fill_reg != '0) && border) : is_full);
    assign store_en   = advance && !cfg.clear && store;
    assign release_en = advance && !cfg.clear && release_ok;

    assign h0 = fwd0_reg ? wr_data_reg : rd0_reg;
    assign h1 = fwd1_reg ? wr_data_reg : rd1_reg;

    // left neighbour and top row already hold smoothed values
    assign sum = SUM_W'(up_left_reg) + SUM_W'(up_reg) + SUM_W'(up_right_reg)
               + SUM_W'(p1_reg) + SUM_W'(h0) + SUM_W'(h1)
               + SUM_W'(t2_reg) + SUM_W'(t1_reg) + SUM_W'(ev_in.value);

    assign rel_val = border ? h0 : div9(sum);

    always_comb
    begin
        fill_next = fill_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        rptr_next = rptr_reg;
        wptr_next = wptr_reg;
        dptr_next = dptr_reg;
        if (cfg.clear)
        begin
            fill_next = '0;
            col_next  = '0;
            row_next  = '0;
            rptr_next = '0;
            wptr_next = '0;
            dptr_next = '0;
        end
        else
        begin
            if (store_en && !release_en)
                fill_next = fill_reg + FW'(1);
            else if (!store_en && release_en)
                fill_next = fill_reg - FW'(1);
            if (store_en)
                wptr_next = (wptr_reg == FA'(FD - 1)) ? '0 : wptr_reg + FA'(1);
            if (release_en)
            begin
                rptr_next = (rptr_reg == FA'(FD - 1)) ? '0 : rptr_reg + FA'(1);
                dptr_next = (dptr_reg == DA'(w_use - WW'(3))) ? '0 : dptr_reg + DA'(1);
                if (at_last_col)
                begin
                    col_next = '0;
                    row_next = at_last_row ? '0 : row_reg + CFG_H_BITS'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
        end
    end

    assign rd1_addr = (rptr_next == FA'(FD - 1)) ? '0 : rptr_next + FA'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            dptr_reg      <= '0;
            fwd0_reg      <= 1'b0;
            fwd1_reg      <= 1'b0;
            evo_valid_reg <= 1'b0;
            evo_tick_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            rptr_reg <= rptr_next;
            wptr_reg <= wptr_next;
            dptr_reg <= dptr_next;
            // bypass when the head slot is written at the same edge it is read
            fwd0_reg <= store_en && (wptr_reg == rptr_next);
            fwd1_reg <= store_en && (wptr_reg == rd1_addr);
            if (cfg.clear)
            begin
                evo_valid_reg <= 1'b0;
                evo_tick_reg  <= 1'b0;
            end
            else if (advance)
            begin
                evo_valid_reg <= ev_in.valid && (ev_in.tick || release_ok);
                evo_tick_reg  <= ev_in.tick && !release_ok;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            raw_mem[wptr_reg] <= ev_in.value;
        rd0_reg <= raw_mem[rptr_next];
        rd1_reg <= raw_mem[rd1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (release_en)
        begin
            up_right_reg       <= hist_mem[dptr_reg];
            hist_mem[dptr_reg] <= rel_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            wr_data_reg <= ev_in.value;
            t1_reg      <= ev_in.value;
            t2_reg      <= t1_reg;
        end
        if (release_en)
        begin
            p1_reg      <= rel_val;
            up_reg      <= up_right_reg;
            up_left_reg <= up_reg;
        end
        if (advance)
        begin
            evo_value_reg <= rel_val;
            evo_last_reg  <= at_last_row && at_last_col;
        end
    end

    assign ev_out.valid = evo_valid_reg;
    assign ev_out.tick  = evo_tick_reg;
    assign ev_out.value = evo_value_reg;
    assign ev_out.last  = evo_last_reg;

endmodule

`default_nettype wire

### src/ipbox_out_buf.sv
// two-entry result buffer decoupling the passes from the result channel
`default_nettype none

module ipbox_out_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  ipbox_pkg::ipbox_res_t push_data,
    output logic                 room,
    ipbox_out_if.source          result
);
    import ipbox_pkg::*;

    logic [1:0] count_reg;
    ipbox_res_t head_reg, tail_reg;
    logic       pop;

    assign pop              = result.valid && result.ready;
    assign room             = count_reg < 2'd2;
    assign result.valid     = count_reg != 2'd0;
    assign result.smoothed  = head_reg.smoothed;
    assign result.frame_end = head_reg.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else if (push && !pop)
            count_reg <= count_reg + 2'd1;
        else if (!push && pop)
            count_reg <= count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_reg <= push_data;
                else
                    tail_reg <= push_data;
            end
            2'b01:   head_reg <= tail_reg;
            2'b11:   head_reg <= push_data;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### src/in_place_box_smoothing_3x3_core.sv
// top level: input register, cascaded smoothing passes and result buffer
// results pass the input register, each pass's output register and the result buffer
// one transaction per cycle unless the out buffer is full; a pass holds width + 1 samples
// flush transactions drain border samples still held at the end of a frame
// rst_n clears control state at once; line memories are not cleared
// a register write restarts all passes at the first position of a frame
`default_nettype none

module in_place_box_smoothing_3x3_core #(
    parameter int MAX_WIDTH = 512,
    parameter int PASSES    = 3
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    ipbox_in_if.sink                            feed,
    ipbox_out_if.source                         result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ipbox_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ipbox_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ipbox_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready
);
    import ipbox_pkg::*;

    ipbox_cfg_t          cfg;
    logic                advance;
    logic                in_valid_reg, in_tick_reg;
    logic [SAMPLE_W-1:0] in_value_reg;
    ipbox_evt_t          in_evt;
    ipbox_evt_t          stage_evt [PASSES];
    ipbox_evt_t          tail_evt;
    ipbox_res_t          res_data;
    logic                push;

    ipbox_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign feed.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cfg.clear)
            in_valid_reg <= 1'b0;
        else if (advance)
            in_valid_reg <= feed.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_tick_reg  <= feed.req_type;
            in_value_reg <= feed.sample;
        end
    end

    assign in_evt.valid = in_valid_reg;
    assign in_evt.tick  = in_tick_reg;
    assign in_evt.value = in_value_reg;
    assign in_evt.last  = 1'b0;

    for (genvar s = 0; s < PASSES; s++)
    begin : g_pass
        if (s == 0)
        begin : g_first
            ipbox_stage #(
                .MAX_WIDTH (MAX_WIDTH)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .cfg     (cfg),
                .ev_in   (in_evt),
                .ev_out  (stage_evt[s])
            );
        end
        else
        begin : g_next
            ipbox_stage #(
                .MAX_WIDTH (MAX_WIDTH)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .cfg     (cfg),
                .ev_in   (stage_evt[s-1]),
                .ev_out  (stage_evt[s])
            );
        end
    end

    assign tail_evt           = stage_evt[PASSES-1];
    assign push               = advance && tail_evt.valid && !tail_evt.tick;
    assign res_data.smoothed  = tail_evt.value;
    assign res_data.frame_end = tail_evt.last;

    ipbox_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_data),
        .room      (advance),
        .result    (result)
    );

endmodule

`default_nettype wire
